// ===== rtl/pad_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pad_pkg
// Shared types and constants for the polar angle and distance pipeline.
// ----------------------------------------------------------------------------
package pad_pkg;

   // coordinate format
   localparam int COORD_BITS = 20;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int TOL_W      = 21;
   localparam int CMP_W      = (COORD_BITS > TOL_W) ? COORD_BITS : TOL_W;

   // CORDIC datapath: magnitudes scaled by 2^8, two growth bits and a sign
   localparam int GUARD_BITS = 8;
   localparam int VEC_W      = COORD_BITS + GUARD_BITS + 3;
   localparam int ZW         = 32;
   localparam int EXTRA_FRAC = 8;
   localparam int QW         = ZW + 1 - EXTRA_FRAC;

   // squared length and square root
   localparam int SQ_FULL_W  = 2 * COORD_BITS + 1;
   localparam int SQ_W       = (SQ_FULL_W > 64) ? 64 : SQ_FULL_W;
   localparam int DIST_SHIFT = 8;
   localparam int M_W        = SQ_W + DIST_SHIFT;
   localparam int SQ_STEPS   = (M_W + 1) / 2;
   localparam int M_PAD_W    = 2 * SQ_STEPS;
   localparam int RW         = SQ_STEPS + 2;

   // result fields
   localparam int ANGLE_W    = 25;
   localparam int DIST_W     = 25;
   localparam int DSQ_OUT_W  = 41;

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_IDX_AXIS_TOL = '0;
   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

   // angles in degrees, 16 fraction bits
   localparam logic [ANGLE_W-1:0] DEG90  = ANGLE_W'(5898240);
   localparam logic [ANGLE_W-1:0] DEG180 = ANGLE_W'(11796480);
   localparam logic [ANGLE_W-1:0] DEG270 = ANGLE_W'(17694720);
   localparam logic [ANGLE_W-1:0] DEG360 = ANGLE_W'(23592960);

   // round(atan(2^-i) * 180/pi * 2^24)
   localparam logic signed [ZW-1:0] ATAN_Q24 [0:31] = '{
      32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
      32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
      32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
      32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
      32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
      32'sd917,       32'sd458,       32'sd229,       32'sd115,
      32'sd57,        32'sd29,        32'sd14,        32'sd7,
      32'sd4,         32'sd2,         32'sd1,         32'sd0
   };

   // how the angle of an item is formed
   typedef logic [2:0] pad_kind_type;
   localparam pad_kind_type KIND_CORDIC = 3'd0;
   localparam pad_kind_type KIND_DEG0   = 3'd1;
   localparam pad_kind_type KIND_DEG90  = 3'd2;
   localparam pad_kind_type KIND_DEG180 = 3'd3;
   localparam pad_kind_type KIND_DEG270 = 3'd4;
   localparam pad_kind_type KIND_UNDEF  = 3'd5;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] origin_x;
      logic signed [COORD_BITS-1:0] origin_y;
      logic signed [COORD_BITS-1:0] target_x;
      logic signed [COORD_BITS-1:0] target_y;
   } pad_req_type;

   typedef struct packed {
      logic [ANGLE_W-1:0]   angle_deg;
      logic [DIST_W-1:0]    distance;
      logic [DSQ_OUT_W-1:0] distance_squared;
      logic                 status;
   } pad_rsp_type;

   typedef struct packed {
      pad_kind_type    kind;
      logic            dx_neg;
      logic            dy_neg;
      logic [SQ_W-1:0] dsq;
   } pad_side_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ZW-1:0]    z;
      logic [M_PAD_W-1:0]      m;
      logic [RW-1:0]           rem;
      logic [SQ_STEPS-1:0]     res;
      pad_side_type            side;
   } pad_cell_type;

endpackage
`default_nettype wire

// ===== rtl/pad_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pad_front
// Difference vector, magnitudes, squares, axis tests and cell-row seeding.
// ----------------------------------------------------------------------------
module pad_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [pad_pkg::TOL_W-1:0]   tolerance,
   input  logic                        req_valid,
   input  pad_pkg::pad_req_type        req_data,
   input  logic [2:0]                  accept,
   output logic [2:0]                  valid,
   output pad_pkg::pad_cell_type       cell_out
);
   import pad_pkg::*;

   logic [2:0] vld_ff;

   // stage A: differences
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, dx_in, dy_in;

   // stage B: magnitudes, squares, angle kind
   logic signed [DIFF_W-1:0]     ax_wide, ay_wide;
   logic signed [2*DIFF_W-1:0]   sqx_full, sqy_full;
   logic [COORD_BITS-1:0]        ax_ff, ay_ff, ax_in, ay_in;
   logic [2*COORD_BITS-1:0]      sqx_ff, sqy_ff, sqx_in, sqy_in;
   pad_kind_type                 kind_ff, kind_in;
   logic                         dxn_ff, dyn_ff;
   logic                         x_axis, y_axis, dx_pos, dy_pos;

   // stage C: seed of the cell row
   logic [SQ_FULL_W-1:0] dsq_full;
   logic [SQ_W-1:0]      dsq;
   pad_cell_type         cell_ff, cell_in;

   assign dx_in = DIFF_W'($signed(req_data.target_x)) - DIFF_W'($signed(req_data.origin_x));
   assign dy_in = DIFF_W'($signed(req_data.target_y)) - DIFF_W'($signed(req_data.origin_y));

   always_comb begin
      ax_wide  = dx_ff[DIFF_W-1] ? -dx_ff : dx_ff;
      ay_wide  = dy_ff[DIFF_W-1] ? -dy_ff : dy_ff;
      ax_in    = ax_wide[COORD_BITS-1:0];
      ay_in    = ay_wide[COORD_BITS-1:0];
      sqx_full = dx_ff * dx_ff;
      sqy_full = dy_ff * dy_ff;
      sqx_in   = sqx_full[2*COORD_BITS-1:0];
      sqy_in   = sqy_full[2*COORD_BITS-1:0];
      x_axis   = CMP_W'(ax_in) < CMP_W'(tolerance);
      y_axis   = CMP_W'(ay_in) < CMP_W'(tolerance);
      dx_pos   = !dx_ff[DIFF_W-1] && (dx_ff != '0);
      dy_pos   = !dy_ff[DIFF_W-1] && (dy_ff != '0);
      if ((x_axis && y_axis) || ((ax_in == '0) && (ay_in == '0))) begin
         kind_in = KIND_UNDEF;
      end else if (x_axis) begin
         kind_in = dy_pos ? KIND_DEG90 : KIND_DEG270;
      end else if (y_axis) begin
         kind_in = dx_pos ? KIND_DEG0 : KIND_DEG180;
      end else begin
         kind_in = KIND_CORDIC;
      end
   end

   always_comb begin
      dsq_full         = SQ_FULL_W'(sqx_ff) + SQ_FULL_W'(sqy_ff);
      dsq              = dsq_full[SQ_W-1:0];
      cell_in.x        = VEC_W'({ax_ff, {GUARD_BITS{1'b0}}});
      cell_in.y        = VEC_W'({ay_ff, {GUARD_BITS{1'b0}}});
      cell_in.z        = '0;
      cell_in.m        = M_PAD_W'({dsq, {DIST_SHIFT{1'b0}}});
      cell_in.rem      = '0;
      cell_in.res      = '0;
      cell_in.side.kind   = kind_ff;
      cell_in.side.dx_neg = dxn_ff;
      cell_in.side.dy_neg = dyn_ff;
      cell_in.side.dsq    = dsq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (accept[0]) vld_ff[0] <= req_valid;
         if (accept[1]) vld_ff[1] <= vld_ff[0];
         if (accept[2]) vld_ff[2] <= vld_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (accept[0]) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (accept[1]) begin
         ax_ff   <= ax_in;
         ay_ff   <= ay_in;
         sqx_ff  <= sqx_in;
         sqy_ff  <= sqy_in;
         kind_ff <= kind_in;
         dxn_ff  <= dx_ff[DIFF_W-1];
         dyn_ff  <= dy_ff[DIFF_W-1];
      end
      if (accept[2]) cell_ff <= cell_in;
   end

   assign valid    = vld_ff;
   assign cell_out = cell_ff;

endmodule
`default_nettype wire

// ===== rtl/pad_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pad_cell
// One row cell: a CORDIC vectoring micro-rotation, one root bit, or both.
// ----------------------------------------------------------------------------
module pad_cell #(
   parameter int IDX     = 0,
   parameter int NUM_ROT = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  valid_in,
   input  pad_pkg::pad_cell_type d_in,
   output logic                  valid_out,
   output pad_pkg::pad_cell_type d_out
);
   import pad_pkg::*;

   localparam bit ROTATE = (IDX < NUM_ROT);
   localparam bit ROOT   = (IDX < SQ_STEPS);
   localparam logic signed [ZW-1:0] STEP_ANGLE = ATAN_Q24[IDX % 32];

   logic                    vld_ff;
   pad_cell_type            d_ff, d_in_next;
   logic signed [VEC_W-1:0] xs, ys;
   logic [RW-1:0]           rem_sh, trial;

   always_comb begin
      d_in_next = d_in;
      xs        = d_in.x >>> IDX;
      ys        = d_in.y >>> IDX;
      rem_sh    = {d_in.rem[RW-3:0], d_in.m[M_PAD_W-1 -: 2]};
      trial     = {d_in.res, 2'b01};
      if (ROTATE) begin
         if (!d_in.y[VEC_W-1]) begin
            d_in_next.x = d_in.x + ys;
            d_in_next.y = d_in.y - xs;
            d_in_next.z = d_in.z + STEP_ANGLE;
         end else begin
            d_in_next.x = d_in.x - ys;
            d_in_next.y = d_in.y + xs;
            d_in_next.z = d_in.z - STEP_ANGLE;
         end
      end
      if (ROOT) begin
         d_in_next.m = d_in.m << 2;
         if (rem_sh >= trial) begin
            d_in_next.rem = rem_sh - trial;
            d_in_next.res = {d_in.res[SQ_STEPS-2:0], 1'b1};
         end else begin
            d_in_next.rem = rem_sh;
            d_in_next.res = {d_in.res[SQ_STEPS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (accept) begin
         vld_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) d_ff <= d_in_next;
   end

   assign valid_out = vld_ff;
   assign d_out     = d_ff;

endmodule
`default_nettype wire

// ===== rtl/pad_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pad_back
// Angle rounding and clamp, quadrant fold and the result register.
// ----------------------------------------------------------------------------
module pad_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            accept,
   input  logic                  valid_in,
   input  pad_pkg::pad_cell_type d_in,
   output logic [1:0]            valid,
   output pad_pkg::pad_rsp_type  rsp_out
);
   import pad_pkg::*;

   logic [1:0] vld_ff;

   // stage D: first-quadrant angle
   logic [ZW:0]            z_round;
   logic [QW-1:0]          q_w;
   logic [ANGLE_W-1:0]     ang_ff, ang_in;
   pad_side_type           side_ff;
   logic [SQ_STEPS-1:0]    res_ff;

   // stage E: result
   pad_rsp_type            rsp_ff, rsp_in;

   always_comb begin
      z_round = {1'b0, d_in.z} + (ZW+1)'(1 << (EXTRA_FRAC - 1));
      q_w     = z_round[ZW:EXTRA_FRAC];
      if (d_in.z[ZW-1]) begin
         ang_in = '0;
      end else if (q_w > QW'(DEG90)) begin
         ang_in = DEG90;
      end else begin
         ang_in = ANGLE_W'(q_w);
      end
   end

   always_comb begin
      rsp_in.distance         = DIST_W'(res_ff);
      rsp_in.distance_squared = DSQ_OUT_W'(side_ff.dsq);
      rsp_in.status           = 1'b0;
      case (side_ff.kind)
         KIND_CORDIC: begin
            if (!side_ff.dx_neg && !side_ff.dy_neg) begin
               rsp_in.angle_deg = ang_ff;
            end else if (!side_ff.dx_neg) begin
               // fourth quadrant; a zero angle would fold to a full turn
               rsp_in.angle_deg = (ang_ff == '0) ? '0 : DEG360 - ang_ff;
            end else if (!side_ff.dy_neg) begin
               rsp_in.angle_deg = DEG180 - ang_ff;
            end else begin
               rsp_in.angle_deg = DEG180 + ang_ff;
            end
         end
         KIND_DEG0:   rsp_in.angle_deg = '0;
         KIND_DEG90:  rsp_in.angle_deg = DEG90;
         KIND_DEG180: rsp_in.angle_deg = DEG180;
         KIND_DEG270: rsp_in.angle_deg = DEG270;
         default: begin
            rsp_in.angle_deg = '0;
            rsp_in.status    = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (accept[0]) vld_ff[0] <= valid_in;
         if (accept[1]) vld_ff[1] <= vld_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (accept[0]) begin
         ang_ff  <= ang_in;
         side_ff <= d_in.side;
         res_ff  <= d_in.res;
      end
      if (accept[1]) rsp_ff <= rsp_in;
   end

   assign valid   = vld_ff;
   assign rsp_out = rsp_ff;

endmodule
`default_nettype wire

// ===== rtl/polar_angle_and_distance.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// polar_angle_and_distance
// Polar angle (degrees, CORDIC vectoring) and distance between two points.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake             payload
//  req_     in         req_valid/req_stall   pad_req_type: origin and target
//  rsp_     out        rsp_valid/rsp_stall   pad_rsp_type: angle, distance,
//                                            squared distance, status
//  csr_     in         APB, pready tied high axis_tolerance at word 0
//
// One transfer per cycle in each direction while rsp_stall is low. The stages
// are three front stages, the cell row, and two back stages; the cell row
// length is set by the longer of the CORDIC iterations and the 25 root bits
// of the distance.
// Synchronous reset clears every stage valid bit and loads axis_tolerance
// with 1. There is no clearing pass.
// Each stage holds only while it and every stage after it are full and
// rsp_stall is high, so bubbles collapse and req_stall rises only when the
// pipe is full.
//
module polar_angle_and_distance #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  pad_pkg::pad_req_type               req_data,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output pad_pkg::pad_rsp_type               rsp_data,

   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pad_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [pad_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pad_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import pad_pkg::*;

   // cell row length and total stage count
   localparam int NC = (CORDIC_STAGES > SQ_STEPS) ? CORDIC_STAGES : SQ_STEPS;
   localparam int NS = 3 + NC + 2;

   logic [NS-1:0] vld;   // valid bit of every stage, input side first
   logic [NS-1:0] acc;   // stage may load this cycle

   pad_cell_type chain [0:NC];

   // ------------------------------------------------------------------
   // register file: axis_tolerance only
   // ------------------------------------------------------------------
   logic [TOL_W-1:0] tol_ff;
   logic             csr_hit;

   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_AXIS_TOL);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(tol_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         tol_ff <= csr_pwdata[TOL_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // flow control: a stage loads when any stage from it onward is empty,
   // or when the result register drains. NAND-reduce over a masked vector.
   // ------------------------------------------------------------------
   genvar gi;
   generate
      for (gi = 0; gi < NS; gi++) begin : g_acc
         localparam logic [NS-1:0] BELOW = {NS{1'b1}} >> (NS - gi);
         assign acc[gi] = (~&(vld | BELOW)) || !rsp_stall;
      end
   endgenerate

   assign req_stall = !acc[0];
   assign rsp_valid = vld[NS-1];

   // ------------------------------------------------------------------
   // datapath
   // ------------------------------------------------------------------
   pad_front u_front (
      .clock     (clock),
      .reset     (reset),
      .tolerance (tol_ff),
      .req_valid (req_valid),
      .req_data  (req_data),
      .accept    (acc[2:0]),
      .valid     (vld[2:0]),
      .cell_out  (chain[0])
   );

   generate
      for (gi = 0; gi < NC; gi++) begin : g_cell
         pad_cell #(
            .IDX     (gi),
            .NUM_ROT (CORDIC_STAGES)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .accept    (acc[3+gi]),
            .valid_in  (vld[2+gi]),
            .d_in      (chain[gi]),
            .valid_out (vld[3+gi]),
            .d_out     (chain[gi+1])
         );
      end
   endgenerate

   pad_back u_back (
      .clock    (clock),
      .reset    (reset),
      .accept   (acc[NS-1:NS-2]),
      .valid_in (vld[NS-3]),
      .d_in     (chain[NC]),
      .valid    (vld[NS-1:NS-2]),
      .rsp_out  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== rtl/pad_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pad_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pad_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  pad_pkg::pad_rsp_type               rsp_data
);
   import pad_pkg::*;

   // stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // undefined angle reads as zero
   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> rsp_data.angle_deg == '0)
      else $error("nonzero angle with undefined status");

   // angle below a full turn
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.angle_deg < DEG360)
      else $error("angle at or above 360 degrees");

   // zero vector has no angle and no length
   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.distance_squared == '0)
      |-> rsp_data.status && (rsp_data.distance == '0))
      else $error("zero vector not flagged");

endmodule

bind polar_angle_and_distance pad_checker u_pad_checker (.*);
`default_nettype wire
